[src/vbsd_pkg.sv]
// ----------------------------------------------------------------------------
// vbsd_pkg
// Shared constants and a helper for the variable-length integer byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vbsd_pkg;

	// Longest item accepted, leading byte included (1 to 8)
	localparam int unsigned MAX_BYTES = 8;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

	// Count of zero bits above the first one bit of a byte, 8 for a zero byte
	function automatic logic [LEN_W-1:0] lead_zeros(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] n;
		logic             found;
		n     = LEN_W'(BYTE_W);
		found = 1'b0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!found && b[i]) begin
				n     = LEN_W'(BYTE_W - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[src/varint_byte_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// varint_byte_stream_decoder_core
// Variable-length unsigned integer decoder, one stream byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / data_byte) carries one raw byte
//   per transaction. The leading zero bits of a leading byte give how many
//   further bytes follow; the data bits are gathered big-endian into value.
//   The output channel (out_valid / out_stall / value, byte_length,
//   overlong_bytes) carries one transaction per completed item. A zero
//   leading byte completes at once with value 0.
//   An item's last byte enters the input register when it is taken and is
//   decoded from there into the result register, which offers the result;
//   a stalled result can hold the byte in the input register. Throughput: one
//   byte per cycle while the output is not stalled, set by the single decode
//   step between the input register and the result register.
//   Reset clears both registers' valid flags and the item in progress, so the
//   next byte is taken as a leading byte.
//   While the receiver stalls a pending result, the input register holds its
//   byte and in_stall rises once that register is occupied; no byte is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_byte_stream_decoder_core
	import vbsd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [BYTE_W-1:0]   data_byte,

	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [VALUE_W-1:0]       value,
	output logic [LEN_W-1:0]         byte_length,
	output logic [LEN_W-1:0]         overlong_bytes
);

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Item in progress
	logic [2:0]         rem_q;
	logic [VALUE_W-1:0] acc_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   zrun_q;
	logic               still_zero_q;

	// Result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [LEN_W-1:0]   len_out_q;
	logic [LEN_W-1:0]   ovl_out_q;

	logic advance;
	logic process;

	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Decode of the byte in the input register
	logic [2:0]         rem_n;
	logic [VALUE_W-1:0] acc_n;
	logic [LEN_W-1:0]   len_n;
	logic [LEN_W-1:0]   zrun_n;
	logic               still_zero_n;
	logic               emit;
	logic [VALUE_W-1:0] res_value;
	logic [LEN_W-1:0]   res_len;
	logic [LEN_W-1:0]   res_ovl;
	logic [LEN_W-1:0]   cnt;
	logic [LEN_W-1:0]   lead_len;
	logic [BYTE_W-1:0]  bits;
	logic [VALUE_W-1:0] lead_acc;
	logic [2:0]         rem_dec;

	always_comb begin
		cnt          = lead_zeros(byte_s1);
		lead_len     = cnt + LEN_W'(1);
		bits         = byte_s1 & (8'hFF >> lead_len);
		lead_acc     = VALUE_W'(bits) << {cnt[2:0], 3'b000};
		rem_dec      = rem_q - 3'd1;

		rem_n        = rem_q;
		acc_n        = acc_q;
		len_n        = len_q;
		zrun_n       = zrun_q;
		still_zero_n = still_zero_q;
		emit         = 1'b0;
		res_value    = acc_q;
		res_len      = len_q;
		res_ovl      = zrun_q;

		if (rem_q == 3'd0) begin
			if (byte_s1 == '0) begin
				emit      = 1'b1;
				res_value = '0;
				res_len   = LEN_W'(1);
				res_ovl   = '0;
			end else if (lead_len > MAX_LEN) begin
				// drop: announced length does not fit
				emit = 1'b0;
			end else begin
				res_value = lead_acc;
				res_len   = lead_len;
				res_ovl   = (bits == '0) ? LEN_W'(1) : '0;
				if (cnt == '0) begin
					emit = 1'b1;
				end else begin
					rem_n        = cnt[2:0];
					acc_n        = lead_acc;
					len_n        = lead_len;
					zrun_n       = res_ovl;
					still_zero_n = (bits == '0);
				end
			end
		end else begin
			acc_n = acc_q | (VALUE_W'(byte_s1) << {rem_dec, 3'b000});
			if (still_zero_q) begin
				if (byte_s1 == '0) begin
					zrun_n = zrun_q + LEN_W'(1);
				end else begin
					still_zero_n = 1'b0;
				end
			end
			rem_n     = rem_dec;
			res_value = acc_n;
			res_len   = len_q;
			res_ovl   = zrun_n;
			emit      = (rem_dec == 3'd0);
		end

		// Return to the idle item state once a result leaves
		if (emit) begin
			rem_n        = '0;
			acc_n        = '0;
			len_n        = '0;
			zrun_n       = '0;
			still_zero_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			byte_s1      <= '0;
			rem_q        <= '0;
			acc_q        <= '0;
			len_q        <= '0;
			zrun_q       <= '0;
			still_zero_q <= 1'b1;
			out_valid_q  <= 1'b0;
			value_q      <= '0;
			len_out_q    <= '0;
			ovl_out_q    <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
				byte_s1  <= data_byte;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end

			if (process) begin
				rem_q        <= rem_n;
				acc_q        <= acc_n;
				len_q        <= len_n;
				zrun_q       <= zrun_n;
				still_zero_q <= still_zero_n;
			end

			if (advance) begin
				out_valid_q <= process && emit;
				if (process && emit) begin
					value_q   <= res_value;
					len_out_q <= res_len;
					ovl_out_q <= res_ovl;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign byte_length    = len_out_q;
	assign overlong_bytes = ovl_out_q;

	// An item in progress has consumed at least its leading byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != 3'd0) |-> (len_q > LEN_W'(rem_q)))
		else $error("item length not above remaining byte count");

	// A blocked input register keeps its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register changed while blocked");

	// Input backpressure comes only from a stalled pending result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && valid_s1))
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
